// ===== rtl/core/ple_pkg.sv =====
// shared types and constants of the positional list engine
package ple_pkg;

  // field widths of the stream words
  localparam int unsigned ActionW   = 3;
  localparam int unsigned PosW      = 7;
  localparam int unsigned ElemPortW = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned FposW     = 6;
  localparam int unsigned LenW      = 7;

  typedef enum logic [ActionW-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_GET    = 3'd2,
    ACT_SET    = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_POP    = 3'd5,
    ACT_SEARCH = 3'd6,
    ACT_CLEAR  = 3'd7
  } action_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // operation that every cell of the row performs
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

endpackage

// ===== rtl/core/ple_cell.sv =====
// one list slot: holds an entry and trades it with its neighbors on shifts
module ple_cell #(
  parameter int unsigned ElemW = 32,
  parameter int unsigned IdxW  = 7,
  parameter int unsigned Idx   = 0
) (
  input  logic              clk_i,
  input  ple_pkg::cell_op_e op_i,
  input  logic [IdxW-1:0]   pos_i,
  input  logic [ElemW-1:0]  elem_i,
  input  logic [ElemW-1:0]  left_i,   // entry of the slot below
  input  logic [ElemW-1:0]  right_i,  // entry of the slot above
  input  logic [ElemW-1:0]  key_i,
  output logic [ElemW-1:0]  entry_o,
  output logic              match_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic [ElemW-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      ple_pkg::CELL_INSERT: begin
        if (MyIdx > pos_i) begin
          entry_d = left_i;
        end else if (MyIdx == pos_i) begin
          entry_d = elem_i;
        end
      end
      ple_pkg::CELL_REMOVE: begin
        if (MyIdx >= pos_i) begin
          entry_d = right_i;
        end
      end
      ple_pkg::CELL_WRITE: begin
        if (MyIdx == pos_i) begin
          entry_d = elem_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q == key_i);

endmodule

// ===== rtl/core/ple_search.sv =====
// first-match encoder over the registered match vector of the row
module ple_search #(
  parameter int unsigned Depth = 64,
  parameter int unsigned SelW  = 6
) (
  input  logic [Depth-1:0] match_i,
  output logic             found_o,
  output logic [SelW-1:0]  index_o
);

  logic [Depth-1:0] lowest;

  // isolate the lowest set bit
  assign lowest  = match_i & (~match_i + Depth'(1));
  assign found_o = |match_i;

  always_comb begin
    index_o = '0;
    for (int i = 0; i < Depth; i++) begin
      if (lowest[i]) begin
        index_o = index_o | SelW'(i);
      end
    end
  end

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Positional list engine: an ordered list of up to CAPACITY element words kept in a
// row of cells. For append, insert, get, set, remove, pop and clear, every cell
// shifts, loads or holds at the edge that accepts the word, and the same edge loads
// its result into the output register. For a search, all cells compare against the
// key as the word is accepted and the match vector is registered; the first-match
// encoder result is loaded into the output register in the cycle after, while the
// input waits. One word is worked on at a time, and a new word is taken as soon as
// the output register is free or is being emptied. No clearing pass follows reset.
module positional_list_engine #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[6:0], element[38:7], zero fill
  input  logic [2:0]  s_axis_tuser,   // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], read_element[33:2], found[34], found_position[40:35],
  // length[47:41], is_empty[48], zero fill
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CntW > ple_pkg::PosW) ? CntW : ple_pkg::PosW;
  localparam int unsigned SelW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned RdW  =
    (ELEMENT_WIDTH > ple_pkg::ElemPortW) ? ELEMENT_WIDTH : ple_pkg::ElemPortW;
  localparam logic [IdxW-1:0] CapIdx = IdxW'(CAPACITY);

  // input word
  ple_pkg::action_e          action;
  logic [ple_pkg::PosW-1:0]  in_pos;
  logic [ple_pkg::ElemPortW-1:0] in_elem;
  logic [RdW-1:0]            elem_wide;
  logic [ELEMENT_WIDTH-1:0]  elem;
  logic [IdxW-1:0]           pos_ext;

  assign action    = ple_pkg::action_e'(s_axis_tuser);
  assign in_pos    = s_axis_tdata[6:0];
  assign in_elem   = s_axis_tdata[38:7];
  assign elem_wide = RdW'(in_elem);
  assign elem      = elem_wide[ELEMENT_WIDTH-1:0];
  assign pos_ext   = IdxW'(in_pos);

  // state
  ple_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] cnt_ext;
  logic [CAPACITY-1:0] match_q;

  assign cnt_ext = IdxW'(count_q);

  // output register
  logic                          out_valid_q, out_valid_d;
  ple_pkg::status_e              status_q, status_d;
  logic [ple_pkg::ElemPortW-1:0] rd_q, rd_d;
  logic                          found_q, found_d;
  logic [ple_pkg::FposW-1:0]     fpos_q, fpos_d;
  logic [ple_pkg::LenW-1:0]      len_q, len_d;
  logic                          empty_q, empty_d;
  logic                          load_out;

  // row of cells
  ple_pkg::cell_op_e        cell_op;
  logic [IdxW-1:0]          cell_pos;
  logic [ELEMENT_WIDTH-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]      cell_match;
  logic [CAPACITY-1:0]      match_live;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry[g+1];
    end

    ple_cell #(
      .ElemW (ELEMENT_WIDTH),
      .IdxW  (IdxW),
      .Idx   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .pos_i   (cell_pos),
      .elem_i  (elem),
      .left_i  (left_w),
      .right_i (right_w),
      .key_i   (elem),
      .entry_o (entry[g]),
      .match_o (cell_match[g])
    );

    // only slots below the length take part in a search
    assign match_live[g] = cell_match[g] && (IdxW'(g) < cnt_ext);
  end

  // entry at the requested position
  logic [ELEMENT_WIDTH-1:0] sel_entry;
  logic [RdW-1:0]           sel_wide;

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IdxW'(i) == pos_ext) begin
        sel_entry = sel_entry | entry[i];
      end
    end
  end

  assign sel_wide = RdW'(sel_entry);

  logic            srch_found;
  logic [SelW-1:0] srch_index;
  logic [IdxW-1:0] srch_index_ext;
  logic [IdxW-1:0] len_ext;

  ple_search #(
    .Depth (CAPACITY),
    .SelW  (SelW)
  ) u_search (
    .match_i (match_q),
    .found_o (srch_found),
    .index_o (srch_index)
  );

  assign srch_index_ext = IdxW'(srch_index);
  assign len_ext        = IdxW'(count_d);

  logic accept;
  logic in_range;
  logic match_load;

  assign s_axis_tready = (state_q == ple_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = pos_ext < cnt_ext;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cell_op     = ple_pkg::CELL_HOLD;
    cell_pos    = pos_ext;
    load_out    = 1'b0;
    match_load  = 1'b0;
    status_d    = ple_pkg::STAT_OK;
    rd_d        = '0;
    found_d     = 1'b0;
    fpos_d      = '0;
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ple_pkg::ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (action)
            ple_pkg::ACT_APPEND, ple_pkg::ACT_INSERT: begin
              if (action == ple_pkg::ACT_APPEND) begin
                cell_pos = cnt_ext;
              end
              if (cell_pos > cnt_ext) begin
                status_d = ple_pkg::STAT_RANGE;
              end else if (cnt_ext == CapIdx) begin
                status_d = ple_pkg::STAT_FULL;
              end else begin
                cell_op = ple_pkg::CELL_INSERT;
                count_d = count_q + CntW'(1);
              end
            end
            ple_pkg::ACT_GET: begin
              if (in_range) begin
                rd_d = sel_wide[ple_pkg::ElemPortW-1:0];
              end else begin
                status_d = ple_pkg::STAT_RANGE;
              end
            end
            ple_pkg::ACT_SET: begin
              if (in_range) begin
                cell_op = ple_pkg::CELL_WRITE;
              end else begin
                status_d = ple_pkg::STAT_RANGE;
              end
            end
            ple_pkg::ACT_REMOVE, ple_pkg::ACT_POP: begin
              if (in_range) begin
                cell_op = ple_pkg::CELL_REMOVE;
                count_d = count_q - CntW'(1);
                if (action == ple_pkg::ACT_POP) begin
                  rd_d = sel_wide[ple_pkg::ElemPortW-1:0];
                end
              end else begin
                status_d = ple_pkg::STAT_RANGE;
              end
            end
            ple_pkg::ACT_SEARCH: begin
              load_out   = 1'b0;
              match_load = 1'b1;
              state_d    = ple_pkg::ST_SEARCH;
            end
            ple_pkg::ACT_CLEAR: begin
              count_d = '0;
            end
            default: begin
              load_out = 1'b0;
            end
          endcase
        end
      end
      ple_pkg::ST_SEARCH: begin
        load_out = 1'b1;
        found_d  = srch_found;
        fpos_d   = srch_index_ext[ple_pkg::FposW-1:0];
        state_d  = ple_pkg::ST_IDLE;
      end
      default: state_d = ple_pkg::ST_IDLE;
    endcase

    len_d   = len_ext[ple_pkg::LenW-1:0];
    empty_d = (count_d == '0);
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match_load) begin
      match_q <= match_live;
    end
    if (load_out) begin
      status_q <= status_d;
      rd_q     <= rd_d;
      found_q  <= found_d;
      fpos_q   <= fpos_d;
      len_q    <= len_d;
      empty_q  <= empty_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, empty_q, len_q, fpos_q, found_q, rd_q, status_q};

endmodule
